// ===== rtl/lzw_compressor_defines.svh =====
// assertion macros used by the lzwc_checker module
`ifndef LZW_COMPRESSOR_DEFINES_SVH
`define LZW_COMPRESSOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LZWC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzw compressor check failed");

// next-cycle implication, disabled while reset is low
`define LZWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzw compressor check failed");

`endif

// ===== rtl/lzwc_pkg.sv =====
package lzwc_pkg;

  // code width and dictionary size (table depth is a power of two)
  localparam int CODE_BITS  = 16;
  localparam int TABLE_BITS = 16;
  localparam int TABLE_ENTRIES = 1 << TABLE_BITS;

  // generation tag kept with every dictionary entry; tag zero is never current
  localparam int EPOCH_BITS = 8;

  localparam logic [CODE_BITS-1:0] NO_PREFIX  = CODE_BITS'((1 << CODE_BITS) - 1);
  localparam logic [CODE_BITS-1:0] FIRST_CODE = CODE_BITS'(256);
  localparam logic [31:0]          HASH_MULT  = 32'd2654435761;

  // one dictionary entry
  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [CODE_BITS-1:0]  prefix;
    logic [7:0]            pair_byte;
    logic [CODE_BITS-1:0]  code;
  } entry_t;

  localparam int ENTRY_W = EPOCH_BITS + 2 * CODE_BITS + 8;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;        // latch input byte, register the hash product
    logic own_prefix;  // prefix takes the incoming byte's own code
    logic rd_first;    // read the dictionary at the hashed slot
    logic rd_next;     // read the next slot (linear probe)
    logic hit_prefix;  // prefix takes the matched code
    logic learn;       // emit prefix, advance next code, prefix takes byte code
    logic store;       // write the new pair into the probed slot
    logic flush;       // emit remaining prefix, clear prefix
    logic drop;        // forget learned entries, next code back to 256
    logic clr_step;    // clearing pass writes one entry
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic no_prefix;
    logic final_byte;
    logic hit;
    logic empty;
    logic last_probe;
    logic refill;
    logic epoch_wrap;
    logic clr_done;
    logic room;
  } status_t;

endpackage

// ===== rtl/lzwc_ram.sv =====
module lzwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lzwc_datapath.sv =====
module lzwc_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_byte,
  input  logic               in_final,
  input  lzwc_pkg::cmd_t     cmd,
  output lzwc_pkg::status_t  st,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,
  output logic               out_tlast
);

  localparam int CB = lzwc_pkg::CODE_BITS;
  localparam int TB = lzwc_pkg::TABLE_BITS;
  localparam int EB = lzwc_pkg::EPOCH_BITS;

  // working registers
  logic [CB-1:0] prefix_r, prefix_nxt;
  logic [CB-1:0] next_code_r, next_code_nxt;
  logic [EB-1:0] epoch_r, epoch_nxt;
  logic [TB-1:0] clr_addr_r, clr_addr_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          final_r, final_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [TB-1:0] slot_r, slot_nxt;
  logic [TB-1:0] probe_r, probe_nxt;

  // output queue
  logic [15:0]   fifo_code_r [4];
  logic          fifo_last_r [4];
  logic [1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [2:0]    fifo_cnt_r, fifo_cnt_nxt;

  logic [31:0]   key;
  logic [31:0]   hash_mix;
  logic [TB-1:0] first_slot;
  logic [TB-1:0] next_slot;
  logic [CB-1:0] own_in;
  logic [CB-1:0] own_r;
  logic [CB-1:0] next_code_inc;

  logic                        ram_we;
  logic [TB-1:0]               ram_waddr;
  lzwc_pkg::entry_t            ram_wentry;
  logic                        ram_re;
  logic [TB-1:0]               ram_raddr;
  logic [lzwc_pkg::ENTRY_W-1:0] ram_rdata;
  lzwc_pkg::entry_t            rd_ent;
  logic                        ent_valid;

  logic push, pop;
  logic push_last;

  // hash of (prefix, byte) and slot folding
  assign key        = {8'd0, 16'(prefix_r), in_byte};
  assign hash_mix   = prod_r ^ (prod_r >> 15);
  assign first_slot = hash_mix[TB-1:0];
  assign next_slot  = slot_r + 1'b1;

  // single-byte codes
  assign own_in        = {{(CB-8){1'b0}}, in_byte ^ 8'h80};
  assign own_r         = {{(CB-8){1'b0}}, byte_r ^ 8'h80};
  assign next_code_inc = next_code_r + 1'b1;

  // dictionary read side compare
  assign rd_ent    = lzwc_pkg::entry_t'(ram_rdata);
  assign ent_valid = (rd_ent.epoch == epoch_r);

  // status to the controller
  always_comb begin
    st.no_prefix  = (prefix_r == lzwc_pkg::NO_PREFIX);
    st.final_byte = final_r;
    st.hit        = ent_valid && (rd_ent.prefix == prefix_r) && (rd_ent.pair_byte == byte_r);
    st.empty      = !ent_valid;
    st.last_probe = (probe_r == {TB{1'b1}});
    st.refill     = (next_code_inc == lzwc_pkg::NO_PREFIX);
    st.epoch_wrap = (epoch_r == {EB{1'b1}});
    st.clr_done   = (clr_addr_r == {TB{1'b1}});
    st.room       = (fifo_cnt_r <= 3'd2);
  end

  // next state of the working registers
  always_comb begin
    prefix_nxt    = prefix_r;
    next_code_nxt = next_code_r;
    epoch_nxt     = epoch_r;
    clr_addr_nxt  = clr_addr_r;
    byte_nxt      = byte_r;
    final_nxt     = final_r;
    prod_nxt      = prod_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;

    if (cmd.take) begin
      byte_nxt  = in_byte;
      final_nxt = in_final;
      prod_nxt  = 32'(key * lzwc_pkg::HASH_MULT);
    end

    priority if (cmd.flush) begin
      prefix_nxt = lzwc_pkg::NO_PREFIX;
    end else if (cmd.own_prefix) begin
      prefix_nxt = own_in;
    end else if (cmd.hit_prefix) begin
      prefix_nxt = rd_ent.code;
    end else if (cmd.learn) begin
      prefix_nxt = own_r;
    end else begin
      prefix_nxt = prefix_r;
    end

    priority if (cmd.drop) begin
      next_code_nxt = lzwc_pkg::FIRST_CODE;
      epoch_nxt     = st.epoch_wrap ? EB'(1) : epoch_r + 1'b1;
    end else if (cmd.learn) begin
      next_code_nxt = next_code_inc;
    end else begin
      next_code_nxt = next_code_r;
    end

    if (cmd.rd_first) begin
      slot_nxt  = first_slot;
      probe_nxt = '0;
    end else if (cmd.rd_next) begin
      slot_nxt  = next_slot;
      probe_nxt = probe_r + 1'b1;
    end

    if (cmd.clr_step) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= lzwc_pkg::NO_PREFIX;
      next_code_r <= lzwc_pkg::FIRST_CODE;
      epoch_r     <= EB'(1);
      clr_addr_r  <= '0;
    end else begin
      prefix_r    <= prefix_nxt;
      next_code_r <= next_code_nxt;
      epoch_r     <= epoch_nxt;
      clr_addr_r  <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    final_r <= final_nxt;
    prod_r  <= prod_nxt;
    slot_r  <= slot_nxt;
    probe_r <= probe_nxt;
  end

  // dictionary ports: clearing pass or learned pair on write, probe on read
  always_comb begin
    ram_we    = cmd.store || cmd.clr_step;
    ram_waddr = cmd.clr_step ? clr_addr_r : slot_r;
    if (cmd.clr_step) begin
      ram_wentry = '0;
    end else begin
      ram_wentry.epoch     = epoch_r;
      ram_wentry.prefix    = prefix_r;
      ram_wentry.pair_byte = byte_r;
      ram_wentry.code      = next_code_r;
    end
    ram_re    = cmd.rd_first || cmd.rd_next;
    ram_raddr = cmd.rd_first ? first_slot : next_slot;
  end

  lzwc_ram #(
    .WIDTH (lzwc_pkg::ENTRY_W),
    .DEPTH (lzwc_pkg::TABLE_ENTRIES)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output queue bookkeeping
  assign push      = cmd.learn || cmd.flush;
  assign push_last = cmd.flush || !final_r;
  assign pop       = out_tvalid && out_tready;

  always_comb begin
    wr_ptr_nxt   = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt   = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   fifo_cnt_nxt = fifo_cnt_r + 1'b1;
      2'b01:   fifo_cnt_nxt = fifo_cnt_r - 1'b1;
      default: fifo_cnt_nxt = fifo_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      fifo_cnt_r <= fifo_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_code_r[wr_ptr_r] <= 16'(prefix_r);
      fifo_last_r[wr_ptr_r] <= push_last;
    end
  end

  assign out_tvalid = (fifo_cnt_r != 3'd0);
  assign out_tdata  = fifo_code_r[rd_ptr_r];
  assign out_tlast  = fifo_last_r[rd_ptr_r];

endmodule

// ===== rtl/lzwc_ctrl.sv =====
module lzwc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  lzwc_pkg::status_t st,
  output lzwc_pkg::cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PROBE = 5'b00100,
    S_CHECK = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE) && st.room;
  assign accept    = in_tvalid && in_tready;

  // sequencing of one byte: take, first probe and compare/probe loop (only with a prefix pending), optional flush
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (st.no_prefix) begin
            cmd.own_prefix = 1'b1;
            state_nxt      = in_tlast ? S_FLUSH : S_IDLE;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        cmd.rd_first = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_CHECK: begin
        priority if (st.hit) begin
          cmd.hit_prefix = 1'b1;
          state_nxt      = st.final_byte ? S_FLUSH : S_IDLE;
        end else if (st.empty || st.last_probe) begin
          // miss: learn the pair if a free slot was found
          cmd.learn = 1'b1;
          cmd.store = st.empty;
          if (st.final_byte) begin
            state_nxt = S_FLUSH;
          end else if (st.refill) begin
            cmd.drop  = 1'b1;
            state_nxt = st.epoch_wrap ? S_CLEAR : S_IDLE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        cmd.drop  = 1'b1;
        state_nxt = st.epoch_wrap ? S_CLEAR : S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/lzw_compressor.sv =====
// lzw compressor: one byte per input transaction; no byte is taken until the one before is
// done with its probes of the single-port dictionary ram and, for a final byte, its flush;
// 4-deep output queue; reset: synchronous active low, then a clearing pass over all
// TABLE_ENTRIES (65536) dictionary entries with in_tready low, repeated after every 255
// dictionary refills or stream ends
module lzw_compressor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code
  output logic        out_tlast   // last_of_run
);

  lzwc_pkg::cmd_t    cmd;
  lzwc_pkg::status_t st;

  lzwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lzwc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_final   (in_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== rtl/lzwc_checker.sv =====
`include "lzw_compressor_defines.svh"

module lzwc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result transaction holds its payload
  `LZWC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // the no-prefix marker is never emitted as a code
  `LZWC_ASSERT_NOW(a_no_marker, out_tvalid, out_tdata != 16'(lzwc_pkg::NO_PREFIX))

  // a final byte is followed by its flush cycle, so no byte is taken right after it
  `LZWC_ASSERT_NEXT(a_final_flush, in_tvalid && in_tready && in_tlast, !in_tready)

  // the first code of a two-code run is always followed by the second
  `LZWC_ASSERT_NEXT(a_run_pair, out_tvalid && out_tready && !out_tlast, out_tvalid)

endmodule

bind lzw_compressor lzwc_checker u_lzwc_checker (.*);

// ===== bench/lzw_code_checker.sv =====
`timescale 1ns / 1ps

// watches both streams of the compressor, predicts the emitted codes and compares them
module lzw_code_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // final_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] code
  input  logic        out_tlast,  // last_of_run
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [lzwc_pkg::CODE_BITS-1:0] code;
    logic                           last;
  } code_txn_t;

  // codes still owed by the block, oldest first
  code_txn_t code_queue[$];

  // predicted compressor state: prefix, next free code, learned phrases keyed by {prefix, byte}
  logic [lzwc_pkg::CODE_BITS-1:0] cur_prefix;
  int unsigned                    next_free;
  logic [lzwc_pkg::CODE_BITS-1:0] phrase_dict [int unsigned];

  // forget learned phrases and restart numbering
  task automatic drop_phrases();
    phrase_dict.delete();
    next_free = 32'(lzwc_pkg::FIRST_CODE);
  endtask

  // advance the prediction by one accepted byte and queue the codes it emits
  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    logic [7:0]  own;
    int unsigned key;
    code_txn_t   t;
    own = b ^ 8'h80;
    // dictionary refill once every code has been handed out
    if (next_free >= lzwc_pkg::NO_PREFIX) drop_phrases();
    if (cur_prefix == lzwc_pkg::NO_PREFIX) begin
      cur_prefix = {8'h00, own};
    end else begin
      key = {8'h00, cur_prefix, b};
      if (phrase_dict.exists(key)) begin
        cur_prefix = phrase_dict[key];
      end else begin
        // miss: learn the pair, emit the old prefix
        phrase_dict[key] = next_free[lzwc_pkg::CODE_BITS-1:0];
        next_free++;
        t.code = cur_prefix;
        t.last = !fin;
        code_queue = {code_queue, t};
        cur_prefix = {8'h00, own};
      end
    end
    // end of stream: flush the prefix and start over
    if (fin) begin
      t.code = cur_prefix;
      t.last = 1'b1;
      code_queue = {code_queue, t};
      drop_phrases();
      cur_prefix = lzwc_pkg::NO_PREFIX;
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    code_txn_t want;
    if (!rst_n) begin
      code_queue.delete();
      drop_phrases();
      cur_prefix = lzwc_pkg::NO_PREFIX;
    end else begin
      if (in_tvalid && in_tready) absorb_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (code_queue.size() == 0) begin
          $error("unexpected code transaction: code %0d last %0b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = code_queue.pop_front();
          if (out_tdata !== want.code) begin
            $error("code mismatch: expected %0d, actual %0d", want.code, out_tdata);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_run mismatch: expected %0b, actual %0b", want.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
    pending <= code_queue.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // cycles without any transaction before the run is declared hung; the clearing
  // pass alone holds the input off while it writes all 65536 dictionary entries
  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 250;
  localparam int TINY_STREAMS = 260;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // final_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [15:0] code
  logic        out_tlast;          // last_of_run

  logic quiet = 1'b0;     // no idling on either side
  logic hold_req = 1'b0;  // ask the receiver for one long hold-off
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_cycles = 0;
  int   fail_count;
  int   pending;

  always #2 clk = ~clk;

  lzw_compressor uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lzw_code_checker code_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver: random backpressure plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 32);
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // offer one byte, with random idle cycles first, and wait for its transaction
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!quiet) begin
      while ($urandom_range(99) < 32) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
  endtask

  // one stream of random bytes, either full range or from a four-byte alphabet
  task automatic send_stream(input int len, input bit narrow);
    logic [7:0] alpha [4];
    logic [7:0] b;
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(255));
    for (int k = 0; k < len; k++) begin
      b = narrow ? alpha[$urandom_range(3)] : 8'($urandom_range(255));
      send_byte(b, k == len - 1);
    end
  endtask

  initial begin
    logic [7:0] pat_a;
    logic [7:0] pat_b;
    int         sent;
    int         len;
    int         pick;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // single-byte streams at the byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h80, 1'b1);
    // repeated byte: hits on learned phrases, final byte on a hit
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b1);
    // alternating codes around the sign boundary, hits on a learned pair
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b1);
    // final byte on a miss: two codes from one transaction
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b1);

    // long stretch with no idling: a repeated pattern so fresh phrases get hit
    quiet <= 1'b1;
    pat_a = 8'($urandom_range(255));
    pat_b = 8'($urandom_range(255));
    for (int k = 0; k < 40; k++) send_byte(k[0] ? pat_b : pat_a, k == 39);
    quiet <= 1'b0;

    // many tiny streams: stream ends pile up past the tag range of the store
    for (int s = 0; s < TINY_STREAMS; s++) send_stream($urandom_range(1, 2), 1'b0);

    // random streams, long receiver hold-off at the start
    hold_req <= 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 55) len = $urandom_range(1, 6);
      else if (pick < 90) len = $urandom_range(8, 40);
      else len = $urandom_range(60, 120);
      send_stream(len, 1'($urandom_range(1)));
      sent += len;
    end

    // drain and settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
